FILE: rtl/fha_pkg.sv
// Shared types and constants for the first-fit heap allocator.
`timescale 1ns / 1ps

package fha_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int IDX_W        = $clog2(MAX_BLOCKS);
  localparam int LINK_W       = IDX_W + 1;
  localparam int ADDR_W       = 30;
  localparam int HEAP_W       = 31;
  localparam int HEADER_BYTES = 32;
  localparam int SPLIT_SLACK  = 64;

  localparam logic [LINK_W-1:0] NO_LINK    = LINK_W'(MAX_BLOCKS);
  localparam logic [IDX_W-1:0]  LAST_STEP  = IDX_W'(MAX_BLOCKS - 1);
  localparam logic [HEAP_W-1:0] HEAP_LIMIT = HEAP_W'(64'd1 << ADDR_W);
  localparam logic [HEAP_W-1:0] HEAP_RESET = HEAP_W'(64'd1 << ADDR_W);
  localparam logic [ADDR_W-1:0] HDR        = ADDR_W'(HEADER_BYTES);

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_OOM     = 2'd1;
  localparam logic [1:0] STAT_UNKNOWN = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] len;
    logic              vacant;
    logic [LINK_W-1:0] fwd;
    logic [LINK_W-1:0] back;
  } desc_t;

  typedef struct packed {
    logic             en;
    logic             ext;
    logic             fwd;
    logic             back;
    logic [IDX_W-1:0] addr;
    desc_t            data;
  } mem_wr_t;

  typedef struct packed {
    logic             set;
    logic             clr;
    logic [IDX_W-1:0] idx;
  } spare_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_WALK,
    ST_SPLIT_J,
    ST_SPLIT_F,
    ST_SPLIT_I,
    ST_TAKE,
    ST_FREE_RDF,
    ST_FREE_NXT,
    ST_FREE_BK,
    ST_FREE_LINK
  } fsm_state_t;

endpackage

FILE: rtl/fha_mem.sv
// Descriptor memory with per-field write mask and reset-value substitution.
`timescale 1ns / 1ps

module fha_mem (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          clr,
  input  logic [fha_pkg::ADDR_W-1:0]    init_len,
  input  fha_pkg::mem_wr_t              wr,
  input  logic [fha_pkg::IDX_W-1:0]     rd_addr,
  output fha_pkg::desc_t                rd_data
);

  fha_pkg::desc_t mem [fha_pkg::MAX_BLOCKS];

  logic [fha_pkg::MAX_BLOCKS-1:0] ext_v_r;
  logic [fha_pkg::MAX_BLOCKS-1:0] fwd_v_r;
  logic [fha_pkg::MAX_BLOCKS-1:0] back_v_r;

  fha_pkg::desc_t q_r;
  logic [2:0]     vq_r;
  logic           zero_q_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      if (wr.ext) begin
        mem[wr.addr].base   <= wr.data.base;
        mem[wr.addr].len    <= wr.data.len;
        mem[wr.addr].vacant <= wr.data.vacant;
      end
      if (wr.fwd) begin
        mem[wr.addr].fwd <= wr.data.fwd;
      end
      if (wr.back) begin
        mem[wr.addr].back <= wr.data.back;
      end
    end
    q_r      <= mem[rd_addr];
    zero_q_r <= (rd_addr == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      ext_v_r  <= '0;
      fwd_v_r  <= '0;
      back_v_r <= '0;
      vq_r     <= '0;
    end else begin
      if (wr.en && wr.ext)  ext_v_r[wr.addr]  <= 1'b1;
      if (wr.en && wr.fwd)  fwd_v_r[wr.addr]  <= 1'b1;
      if (wr.en && wr.back) back_v_r[wr.addr] <= 1'b1;
      vq_r <= {ext_v_r[rd_addr], fwd_v_r[rd_addr], back_v_r[rd_addr]};
    end
  end

  // unwritten fields read as the heap's initial layout
  always_comb begin
    rd_data = q_r;
    if (!vq_r[2]) begin
      rd_data.base   = '0;
      rd_data.len    = zero_q_r ? init_len : '0;
      rd_data.vacant = zero_q_r;
    end
    if (!vq_r[1]) rd_data.fwd  = zero_q_r ? fha_pkg::NO_LINK : '0;
    if (!vq_r[0]) rd_data.back = zero_q_r ? fha_pkg::NO_LINK : '0;
  end

endmodule

FILE: rtl/fha_spare.sv
// Live-descriptor bitmap, spare counter and lowest-spare finder.
`timescale 1ns / 1ps

module fha_spare (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      clr,
  input  fha_pkg::spare_op_t        op,
  output logic                      avail,
  output logic [fha_pkg::IDX_W-1:0] spare_idx
);

  logic [fha_pkg::MAX_BLOCKS-1:0] live_r;
  logic [fha_pkg::IDX_W:0]        count_r;
  logic                           found;

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      live_r  <= fha_pkg::MAX_BLOCKS'(1);
      count_r <= (fha_pkg::IDX_W + 1)'(fha_pkg::MAX_BLOCKS - 1);
    end else if (op.set) begin
      live_r[op.idx] <= 1'b1;
      count_r        <= count_r - 1'b1;
    end else if (op.clr) begin
      live_r[op.idx] <= 1'b0;
      count_r        <= count_r + 1'b1;
    end
  end

  // lowest dead descriptor above entry 0
  always_comb begin
    found     = 1'b0;
    spare_idx = '0;
    for (int k = fha_pkg::MAX_BLOCKS - 1; k >= 1; k--) begin
      if (!live_r[k]) begin
        found     = 1'b1;
        spare_idx = fha_pkg::IDX_W'(k);
      end
    end
  end

  assign avail = found && (count_r != '0);

endmodule

FILE: rtl/first_fit_heap_allocator.sv
// Top level: first-fit heap allocator sequencer around the descriptor memory.
`timescale 1ns / 1ps

// An item is taken when start is high and busy is low; its result appears on
// the out_ ports for one cycle with out_valid and cannot be held off. A free of
// offset 0 answers in the next cycle without raising busy. Any other item takes
// a setup state, then walks the descriptor chain one descriptor per cycle
// through the memory read port (at most 64 descriptors), then any split, take or
// merge states; the result comes in the cycle in which busy falls. No clearing
// pass is needed after reset or a heap_bytes write; the heap is a single free
// block at once.
module first_fit_heap_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_req_type,
  input  logic [29:0]                   in_req_size,
  input  logic [16:0]                   in_alignment,
  input  logic [29:0]                   in_free_offset,
  input  logic                          cfg_we,
  input  logic [30:0]                   cfg_wdata,
  output logic                          out_valid,
  output logic [29:0]                   out_data_offset,
  output logic [1:0]                    out_status,
  output logic [29:0]                   out_bytes_in_use
);

  localparam int AW = fha_pkg::ADDR_W;
  localparam int IW = fha_pkg::IDX_W;
  localparam int LW = fha_pkg::LINK_W;

  fha_pkg::fsm_state_t state_r, state_nxt;

  logic                          op_free_r, op_free_nxt;
  logic [AW-1:0]                 off_r, off_nxt;
  logic [AW:0]                   aligned_r, aligned_nxt;
  logic [AW+1:0]                 need_r, need_nxt;
  logic [AW+1:0]                 thr_r, thr_nxt;
  logic [IW-1:0]                 idx_r, idx_nxt;
  logic [IW-1:0]                 steps_r, steps_nxt;
  fha_pkg::desc_t                desc_r, desc_nxt;
  logic [LW-1:0]                 aux_r, aux_nxt;
  logic [AW-1:0]                 lenacc_r, lenacc_nxt;
  logic [AW-1:0]                 alloc_r, alloc_nxt;
  logic [fha_pkg::HEAP_W-1:0]    heap_r;
  logic                          out_valid_r, out_valid_nxt;
  logic [AW-1:0]                 out_off_r, out_off_nxt;
  logic [1:0]                    out_stat_r, out_stat_nxt;
  logic [AW-1:0]                 out_bytes_r, out_bytes_nxt;

  fha_pkg::mem_wr_t              wr;
  fha_pkg::spare_op_t            sp;
  logic [IW-1:0]                 rd_addr;
  fha_pkg::desc_t                rd;
  logic                          sp_avail;
  logic [IW-1:0]                 sp_idx;

  logic [fha_pkg::HEAP_W-1:0]    heap_eff;
  logic [AW-1:0]                 init_len;
  logic [16:0]                   align_eff;
  logic                          zero_free;
  logic                          hit, split_ok, step_ok, f_merge, b_merge;
  logic [AW+1:0]                 j_base;

  assign heap_eff = (heap_r > fha_pkg::HEAP_LIMIT) ? fha_pkg::HEAP_LIMIT : heap_r;
  assign init_len = (heap_eff > fha_pkg::HEAP_W'(fha_pkg::HEADER_BYTES))
                    ? AW'(heap_eff - fha_pkg::HEAP_W'(fha_pkg::HEADER_BYTES)) : '0;

  fha_mem u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (cfg_we),
    .init_len (init_len),
    .wr       (wr),
    .rd_addr  (rd_addr),
    .rd_data  (rd)
  );

  fha_spare u_spare (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (cfg_we),
    .op        (sp),
    .avail     (sp_avail),
    .spare_idx (sp_idx)
  );

  assign align_eff = (in_alignment == '0) ? 17'd1 : in_alignment;
  assign zero_free = in_req_type && (in_free_offset == '0);

  assign hit = op_free_r
             ? (!rd.vacant && (({1'b0, rd.base} + (AW + 1)'(fha_pkg::HEADER_BYTES))
                               == {1'b0, off_r}))
             : (rd.vacant && ({2'b0, rd.len} >= need_r));
  assign split_ok = ({2'b0, rd.len} >= thr_r) && sp_avail;
  assign step_ok  = (rd.fwd < fha_pkg::NO_LINK) && (steps_r != fha_pkg::LAST_STEP);
  assign f_merge  = (desc_r.fwd < fha_pkg::NO_LINK) && rd.vacant;
  assign b_merge  = (desc_r.back < fha_pkg::NO_LINK) && rd.vacant;
  assign j_base   = {2'b0, desc_r.base} + need_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fha_pkg::ST_IDLE: begin
        if (start && !zero_free) state_nxt = fha_pkg::ST_PREP;
      end
      fha_pkg::ST_PREP:  state_nxt = fha_pkg::ST_WALK;
      fha_pkg::ST_WALK: begin
        if (hit) begin
          if (op_free_r)     state_nxt = fha_pkg::ST_FREE_RDF;
          else if (split_ok) state_nxt = fha_pkg::ST_SPLIT_J;
          else               state_nxt = fha_pkg::ST_TAKE;
        end else if (!step_ok) begin
          state_nxt = fha_pkg::ST_IDLE;
        end
      end
      fha_pkg::ST_SPLIT_J: begin
        state_nxt = (desc_r.fwd < fha_pkg::NO_LINK) ? fha_pkg::ST_SPLIT_F
                                                    : fha_pkg::ST_SPLIT_I;
      end
      fha_pkg::ST_SPLIT_F:  state_nxt = fha_pkg::ST_SPLIT_I;
      fha_pkg::ST_SPLIT_I:  state_nxt = fha_pkg::ST_IDLE;
      fha_pkg::ST_TAKE:     state_nxt = fha_pkg::ST_IDLE;
      fha_pkg::ST_FREE_RDF: state_nxt = fha_pkg::ST_FREE_NXT;
      fha_pkg::ST_FREE_NXT: state_nxt = fha_pkg::ST_FREE_BK;
      fha_pkg::ST_FREE_BK: begin
        state_nxt = (b_merge && (aux_r < fha_pkg::NO_LINK)) ? fha_pkg::ST_FREE_LINK
                                                            : fha_pkg::ST_IDLE;
      end
      fha_pkg::ST_FREE_LINK: state_nxt = fha_pkg::ST_IDLE;
      default:               state_nxt = fha_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    op_free_nxt   = op_free_r;
    off_nxt       = off_r;
    aligned_nxt   = aligned_r;
    need_nxt      = need_r;
    thr_nxt       = thr_r;
    idx_nxt       = idx_r;
    steps_nxt     = steps_r;
    desc_nxt      = desc_r;
    aux_nxt       = aux_r;
    lenacc_nxt    = lenacc_r;
    alloc_nxt     = alloc_r;
    out_valid_nxt = 1'b0;
    out_off_nxt   = out_off_r;
    out_stat_nxt  = out_stat_r;
    out_bytes_nxt = out_bytes_r;
    wr            = '0;
    sp            = '0;
    rd_addr       = '0;
    case (state_r)
      fha_pkg::ST_IDLE: begin
        if (start) begin
          op_free_nxt = in_req_type;
          off_nxt     = in_free_offset;
          aligned_nxt = (({1'b0, in_req_size} + (AW + 1)'(align_eff)) - 1'b1)
                        & ~((AW + 1)'(align_eff) - 1'b1);
          if (zero_free) begin
            out_valid_nxt = 1'b1;
            out_off_nxt   = '0;
            out_stat_nxt  = fha_pkg::STAT_OK;
          end
        end
      end
      fha_pkg::ST_PREP: begin
        need_nxt  = {1'b0, aligned_r} + (AW + 2)'(fha_pkg::HEADER_BYTES);
        thr_nxt   = {1'b0, aligned_r}
                    + (AW + 2)'(2 * fha_pkg::HEADER_BYTES + fha_pkg::SPLIT_SLACK);
        idx_nxt   = '0;
        steps_nxt = '0;
      end
      fha_pkg::ST_WALK: begin
        if (hit) begin
          desc_nxt = rd;
          aux_nxt  = {1'b0, sp_idx};
        end else if (step_ok) begin
          rd_addr   = rd.fwd[IW-1:0];
          idx_nxt   = rd.fwd[IW-1:0];
          steps_nxt = steps_r + 1'b1;
        end else begin
          out_valid_nxt = 1'b1;
          out_off_nxt   = '0;
          out_stat_nxt  = op_free_r ? fha_pkg::STAT_UNKNOWN : fha_pkg::STAT_OOM;
        end
      end
      fha_pkg::ST_SPLIT_J: begin
        // new free remainder after the taken block
        wr.en          = 1'b1;
        wr.ext         = 1'b1;
        wr.fwd         = 1'b1;
        wr.back        = 1'b1;
        wr.addr        = aux_r[IW-1:0];
        wr.data.base   = j_base[AW-1:0];
        wr.data.len    = desc_r.len - need_r[AW-1:0];
        wr.data.vacant = 1'b1;
        wr.data.fwd    = desc_r.fwd;
        wr.data.back   = {1'b0, idx_r};
        sp.set         = 1'b1;
        sp.idx         = aux_r[IW-1:0];
      end
      fha_pkg::ST_SPLIT_F: begin
        wr.en        = 1'b1;
        wr.back      = 1'b1;
        wr.addr      = desc_r.fwd[IW-1:0];
        wr.data.back = aux_r;
      end
      fha_pkg::ST_SPLIT_I: begin
        wr.en          = 1'b1;
        wr.ext         = 1'b1;
        wr.fwd         = 1'b1;
        wr.addr        = idx_r;
        wr.data.base   = desc_r.base;
        wr.data.len    = aligned_r[AW-1:0];
        wr.data.vacant = 1'b0;
        wr.data.fwd    = aux_r;
        alloc_nxt      = alloc_r + aligned_r[AW-1:0];
        out_valid_nxt  = 1'b1;
        out_off_nxt    = desc_r.base + fha_pkg::HDR;
        out_stat_nxt   = fha_pkg::STAT_OK;
      end
      fha_pkg::ST_TAKE: begin
        wr.en          = 1'b1;
        wr.ext         = 1'b1;
        wr.addr        = idx_r;
        wr.data.base   = desc_r.base;
        wr.data.len    = desc_r.len;
        wr.data.vacant = 1'b0;
        alloc_nxt      = alloc_r + desc_r.len;
        out_valid_nxt  = 1'b1;
        out_off_nxt    = desc_r.base + fha_pkg::HDR;
        out_stat_nxt   = fha_pkg::STAT_OK;
      end
      fha_pkg::ST_FREE_RDF: begin
        rd_addr    = desc_r.fwd[IW-1:0];
        alloc_nxt  = alloc_r - desc_r.len;
        lenacc_nxt = desc_r.len;
        aux_nxt    = desc_r.fwd;
      end
      fha_pkg::ST_FREE_NXT: begin
        rd_addr = desc_r.back[IW-1:0];
        if (f_merge) begin
          // absorb the free follower and drop its descriptor
          lenacc_nxt = lenacc_r + fha_pkg::HDR + rd.len;
          aux_nxt    = rd.fwd;
          sp.clr     = 1'b1;
          sp.idx     = desc_r.fwd[IW-1:0];
          if (rd.fwd < fha_pkg::NO_LINK) begin
            wr.en        = 1'b1;
            wr.back      = 1'b1;
            wr.addr      = rd.fwd[IW-1:0];
            wr.data.back = {1'b0, idx_r};
          end
        end
      end
      fha_pkg::ST_FREE_BK: begin
        wr.en          = 1'b1;
        wr.ext         = 1'b1;
        wr.fwd         = 1'b1;
        wr.data.vacant = 1'b1;
        wr.data.fwd    = aux_r;
        if (b_merge) begin
          wr.addr      = desc_r.back[IW-1:0];
          wr.data.base = rd.base;
          wr.data.len  = rd.len + fha_pkg::HDR + lenacc_r;
          sp.clr       = 1'b1;
          sp.idx       = idx_r;
        end else begin
          wr.addr      = idx_r;
          wr.data.base = desc_r.base;
          wr.data.len  = lenacc_r;
        end
        if (!(b_merge && (aux_r < fha_pkg::NO_LINK))) begin
          out_valid_nxt = 1'b1;
          out_off_nxt   = '0;
          out_stat_nxt  = fha_pkg::STAT_OK;
        end
      end
      fha_pkg::ST_FREE_LINK: begin
        wr.en         = 1'b1;
        wr.back       = 1'b1;
        wr.addr       = aux_r[IW-1:0];
        wr.data.back  = desc_r.back;
        out_valid_nxt = 1'b1;
        out_off_nxt   = '0;
        out_stat_nxt  = fha_pkg::STAT_OK;
      end
      default: begin
        wr = '0;
      end
    endcase
    if (out_valid_nxt) out_bytes_nxt = alloc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fha_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      heap_r      <= fha_pkg::HEAP_RESET;
      alloc_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        heap_r  <= cfg_wdata;
        alloc_r <= '0;
      end else begin
        alloc_r <= alloc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_free_r   <= op_free_nxt;
    off_r       <= off_nxt;
    aligned_r   <= aligned_nxt;
    need_r      <= need_nxt;
    thr_r       <= thr_nxt;
    idx_r       <= idx_nxt;
    steps_r     <= steps_nxt;
    desc_r      <= desc_nxt;
    aux_r       <= aux_nxt;
    lenacc_r    <= lenacc_nxt;
    out_off_r   <= out_off_nxt;
    out_stat_r  <= out_stat_nxt;
    out_bytes_r <= out_bytes_nxt;
  end

  assign busy             = (state_r != fha_pkg::ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_data_offset  = out_off_r;
  assign out_status       = out_stat_r;
  assign out_bytes_in_use = out_bytes_r;

endmodule

FILE: rtl/fha_checker.sv
// Port-level checks for the heap allocator, bound to the top level.
`timescale 1ns / 1ps

module fha_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_req_type,
  input logic        out_valid,
  input logic [29:0] out_data_offset,
  input logic [1:0]  out_status
);

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == fha_pkg::STAT_OK || out_status == fha_pkg::STAT_OOM
                   || out_status == fha_pkg::STAT_UNKNOWN))
    else $error("undefined status code");

  a_fail_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != fha_pkg::STAT_OK |-> out_data_offset == '0)
    else $error("failed item carries an offset");

  a_alloc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_req_type |=> busy)
    else $error("allocate item did not raise busy");

  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  a_offset_past_header: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data_offset != '0 |-> out_data_offset >= 30'(fha_pkg::HEADER_BYTES))
    else $error("data offset inside the first header");

endmodule

bind first_fit_heap_allocator fha_checker u_fha_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_req_type     (in_req_type),
  .out_valid       (out_valid),
  .out_data_offset (out_data_offset),
  .out_status      (out_status)
);
